// ===== sv/ifca_pkg.sv =====
// Package for the inode free-cache allocator.
// Holds word field widths, the inode count, operation and status codes, queue word types and states.
// No dependencies.
package ifca_pkg;

  localparam int NUM_W  = 9;
  localparam int STAT_W = 2;

  // Inode numbers run 0..NUM_INODES-1; the word fields are NUM_W bits wide.
  localparam int NUM_INODES = 512;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_ALLOCATED = 2'd0,
    STAT_NONE_FREE = 2'd1,
    STAT_FREED     = 2'd2,
    STAT_REJECTED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_REJECT = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [NUM_W-1:0]  number;
  } cmd_t;

  typedef struct packed {
    logic [NUM_W-1:0]  inode;
    status_t           status;
  } res_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_FREE_RD,
    BK_POP_RD,
    BK_SCAN,
    BK_SCAN_END
  } back_state_t;

endpackage

// ===== sv/inode_free_cache_allocator_unit.sv =====
// Top level of the inode free-cache allocator.
// Depends on ifca_pkg, ifca_front, ifca_fifo and ifca_back.
//
// Usage:
//   Request side is a queue input: drive in_operation / in_inode_number and
//   raise push; the word is taken on a clock edge where push is high and full
//   is low. Result side is a queue output: while empty is low, out_result_inode
//   and out_status hold the oldest result; raise pop to take it.
// Order: a reject is answered from the idle state, a free after its map
//   read, an allocate from the cache after its stack read. An allocate that
//   finds the cache empty scans the used map one inode per cycle from the
//   scan start, up to the end of the map or until the cache is full, then
//   reads the stack; none free is answered from idle or after a scan that
//   finds nothing. The back end handles one request at a time.
// Reset: rst_n (synchronous, active low) empties both queues, sets the cache
//   empty, the free count to NUM_INODES and the scan start to 0, then clears
//   the used map in a pass over all NUM_INODES inodes; full stays high meanwhile.
// Stall: when the receiver holds off pop, the two-entry result queue fills,
//   the back end stops taking commands, the command queue fills and full
//   rises; nothing is dropped.
module inode_free_cache_allocator_unit
  import ifca_pkg::*;
#(
  parameter int CACHE_DEPTH = 50
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic              in_operation,
  input  logic [NUM_W-1:0]  in_inode_number,
  output logic              empty,
  input  logic              pop,
  output logic [NUM_W-1:0]  out_result_inode,
  output logic [STAT_W-1:0] out_status
);

  cmd_t cmd_word;
  cmd_t cmd_head;
  res_t res_word;
  res_t res_head;

  logic cmd_full, cmd_empty, cmd_pop;
  logic res_full, res_push;
  logic clearing;

  logic [$bits(cmd_t)-1:0] cmd_head_bits;
  logic [$bits(res_t)-1:0] res_head_bits;

  // Hold off requests while the command queue is full or the map is clearing.
  assign full = cmd_full | clearing;

  ifca_front u_front (
    .operation    (in_operation),
    .inode_number (in_inode_number),
    .cmd          (cmd_word)
  );

  ifca_fifo #(
    .WIDTH ($bits(cmd_t))
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push & ~full),
    .wr_data (cmd_word),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_head_bits),
    .empty   (cmd_empty)
  );

  assign cmd_head = cmd_t'(cmd_head_bits);

  // Back end takes a command only when the result queue has room, so its
  // result push at the end always lands.
  ifca_back #(
    .CACHE_DEPTH (CACHE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (~cmd_empty),
    .cmd_in    (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_room  (~res_full),
    .res_push  (res_push),
    .res_data  (res_word),
    .clearing  (clearing)
  );

  ifca_fifo #(
    .WIDTH ($bits(res_t))
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_word),
    .full    (res_full),
    .rd_en   (pop & ~empty),
    .rd_data (res_head_bits),
    .empty   (empty)
  );

  // Present the oldest result word on the output ports.
  assign res_head         = res_t'(res_head_bits);
  assign out_result_inode = res_head.inode;
  assign out_status       = res_head.status;

endmodule

// ===== sv/ifca_fifo.sv =====
// Two-entry word queue used between the front and back, and on the result side.
// Depends on nothing but its WIDTH parameter.
module ifca_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ wr_en;
    rd_ptr_nxt = rd_ptr_r ^ rd_en;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 2'd1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== sv/ifca_front.sv =====
// Front end: classifies an incoming request into a command word.
// Depends on ifca_pkg.
module ifca_front
  import ifca_pkg::*;
(
  input  logic             operation,
  input  logic [NUM_W-1:0] inode_number,
  output cmd_t             cmd
);

  logic out_of_range;

  assign out_of_range = (32'(inode_number) >= 32'(NUM_INODES));

  always_comb begin
    cmd.number = inode_number;
    if (operation == OP_ALLOC) begin
      cmd.kind = CMD_ALLOC;
    end else if (out_of_range) begin
      cmd.kind = CMD_REJECT;
    end else begin
      cmd.kind = CMD_FREE;
    end
  end

endmodule

// ===== sv/ifca_back.sv =====
// Back end: sequencer that owns the used map, the free-number stack and the counters.
// Depends on ifca_pkg.
module ifca_back
  import ifca_pkg::*;
#(
  parameter int CACHE_DEPTH = 50
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cmd_t cmd_in,
  output logic cmd_pop,
  input  logic res_room,
  output logic res_push,
  output res_t res_data,
  output logic clearing
);

  localparam int IW  = $clog2(NUM_INODES);
  localparam int CW  = $clog2(NUM_INODES + 1);
  localparam int SW  = $clog2(CACHE_DEPTH + 1);
  localparam int SIW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

  localparam logic [CW-1:0] INODES_C = CW'(NUM_INODES);
  localparam logic [SW-1:0] DEPTH_C  = SW'(CACHE_DEPTH);
  localparam logic [IW-1:0] LAST_C   = IW'(NUM_INODES - 1);

  logic          map_mem  [NUM_INODES];
  logic [IW-1:0] stk_mem  [CACHE_DEPTH];

  back_state_t   state_r, state_nxt;
  logic [SW-1:0] sp_r, sp_nxt;
  logic [CW-1:0] free_total_r, free_total_nxt;
  logic [CW-1:0] scan_start_r, scan_start_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [SW-1:0] found_r, found_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [IW-1:0] clr_r, clr_nxt;
  cmd_t          cmd_r, cmd_nxt;

  logic          map_q_r;
  logic [IW-1:0] stk_q_r;

  logic           map_we, map_wdata;
  logic [IW-1:0]  map_waddr, map_raddr;
  logic           stk_we;
  logic [SIW-1:0] stk_waddr, stk_raddr;
  logic [IW-1:0]  stk_wdata;

  logic [CW-1:0] pos_inc;
  logic [SW-1:0] slot_dec, sp_dec;
  logic [IW-1:0] cmd_num;

  assign pos_inc  = pos_r + CW'(1);
  assign slot_dec = slot_r - SW'(1);
  assign sp_dec   = sp_r - SW'(1);
  assign cmd_num  = IW'(cmd_r.number);
  assign clearing = (state_r == BK_CLEAR);

  always_comb begin
    state_nxt      = state_r;
    sp_nxt         = sp_r;
    free_total_nxt = free_total_r;
    scan_start_nxt = scan_start_r;
    pos_nxt        = pos_r;
    found_nxt      = found_r;
    slot_nxt       = slot_r;
    clr_nxt        = clr_r;
    cmd_nxt        = cmd_r;
    cmd_pop        = 1'b0;
    res_push       = 1'b0;
    res_data       = '{inode: '0, status: STAT_NONE_FREE};
    map_we         = 1'b0;
    map_wdata      = 1'b0;
    map_waddr      = cmd_num;
    map_raddr      = '0;
    stk_we         = 1'b0;
    stk_waddr      = '0;
    stk_wdata      = '0;
    stk_raddr      = '0;

    case (state_r)
      BK_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_r;
        clr_nxt   = clr_r + IW'(1);
        if (clr_r == LAST_C) begin
          state_nxt = BK_IDLE;
        end
      end

      BK_IDLE: begin
        if (cmd_valid && res_room) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd_in;
          case (cmd_in.kind)
            CMD_FREE: begin
              map_raddr = IW'(cmd_in.number);
              state_nxt = BK_FREE_RD;
            end
            CMD_ALLOC: begin
              if (free_total_r == '0) begin
                res_push = 1'b1;
              end else if (sp_r == DEPTH_C) begin
                if (scan_start_r == INODES_C) begin
                  res_push = 1'b1;
                end else begin
                  map_raddr = scan_start_r[IW-1:0];
                  pos_nxt   = scan_start_r;
                  found_nxt = '0;
                  slot_nxt  = DEPTH_C;
                  state_nxt = BK_SCAN;
                end
              end else begin
                stk_raddr = sp_r[SIW-1:0];
                state_nxt = BK_POP_RD;
              end
            end
            default: begin
              res_push = 1'b1;
              res_data = '{inode: cmd_in.number, status: STAT_REJECTED};
            end
          endcase
        end
      end

      BK_FREE_RD: begin
        if (map_q_r) begin
          map_we         = 1'b1;
          free_total_nxt = free_total_r + CW'(1);
          if (sp_r != '0) begin
            sp_nxt    = sp_dec;
            stk_we    = 1'b1;
            stk_waddr = sp_dec[SIW-1:0];
            stk_wdata = cmd_num;
          end else if (CW'(cmd_num) < scan_start_r) begin
            scan_start_nxt = CW'(cmd_num);
          end
        end
        res_push  = 1'b1;
        res_data  = '{inode: cmd_r.number, status: STAT_FREED};
        state_nxt = BK_IDLE;
      end

      BK_POP_RD: begin
        map_we         = 1'b1;
        map_wdata      = 1'b1;
        map_waddr      = stk_q_r;
        sp_nxt         = sp_r + SW'(1);
        free_total_nxt = free_total_r - CW'(1);
        res_push       = 1'b1;
        res_data       = '{inode: NUM_W'(stk_q_r), status: STAT_ALLOCATED};
        state_nxt      = BK_IDLE;
      end

      BK_SCAN: begin
        if (!map_q_r) begin
          stk_we         = 1'b1;
          stk_waddr      = slot_dec[SIW-1:0];
          stk_wdata      = pos_r[IW-1:0];
          slot_nxt       = slot_dec;
          found_nxt      = found_r + SW'(1);
          scan_start_nxt = pos_inc;
        end
        pos_nxt = pos_inc;
        if (pos_inc == INODES_C || found_nxt == DEPTH_C) begin
          state_nxt = BK_SCAN_END;
        end else begin
          map_raddr = pos_inc[IW-1:0];
        end
      end

      BK_SCAN_END: begin
        if (found_r == '0) begin
          res_push  = 1'b1;
          state_nxt = BK_IDLE;
        end else begin
          sp_nxt    = slot_r;
          stk_raddr = slot_r[SIW-1:0];
          state_nxt = BK_POP_RD;
        end
      end

      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_CLEAR;
      clr_r        <= '0;
      sp_r         <= DEPTH_C;
      free_total_r <= INODES_C;
      scan_start_r <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      sp_r         <= sp_nxt;
      free_total_r <= free_total_nxt;
      scan_start_r <= scan_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    found_r <= found_nxt;
    slot_r  <= slot_nxt;
    cmd_r   <= cmd_nxt;
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_q_r <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_q_r <= stk_mem[stk_raddr];
  end

endmodule

// ===== tb/tb_inode_free_cache_allocator_unit.sv =====
// Self-checking testbench for inode_free_cache_allocator_unit.
// Drives allocate/free words through the request queue and checks each result word
// against an in-bench allocator predictor. Depends on ifca_pkg and the DUT only.
`timescale 1ns / 1ps

module tb_inode_free_cache_allocator_unit;
  import ifca_pkg::*;

  localparam int CACHE_DEPTH = 50;
  // A refill may scan the whole map, so settle for longer than one full scan.
  localparam int DRAIN_CYCLES = NUM_INODES + 8;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int RANDOM_WORDS = 930;

  typedef struct packed {
    logic             op;
    logic [NUM_W-1:0] num;
  } request_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic              in_operation = OP_ALLOC;
  logic [NUM_W-1:0]  in_inode_number = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [NUM_W-1:0]  out_result_inode;
  logic [STAT_W-1:0] out_status;

  // Predictor state: used map, free-number cache, free count and scan start.
  bit               used_bits [NUM_INODES];
  logic [NUM_W-1:0] free_cache [CACHE_DEPTH];
  int               cache_top;
  int               free_count;
  int               scan_from;

  request_t pending_requests [$];
  res_t     expected_results [$];
  int       error_count = 0;
  int       cycle_count = 0;
  int       words_queued = 0;

  int send_wait = 0;
  int recv_wait = 0;
  bit send_fast = 1'b0;
  bit recv_fast = 1'b0;

  inode_free_cache_allocator_unit #(
    .CACHE_DEPTH(CACHE_DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_operation    (in_operation),
    .in_inode_number (in_inode_number),
    .empty           (empty),
    .pop             (pop),
    .out_result_inode(out_result_inode),
    .out_status      (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the result word of one accepted request and advance the predictor.
  task automatic predict_allocator(input logic op, input logic [NUM_W-1:0] num);
    res_t r;
    int   pos;
    int   found;
    int   slot;
    r.inode  = '0;
    r.status = STAT_NONE_FREE;
    if (op == OP_ALLOC) begin
      if (free_count != 0) begin
        // Cache empty: reload it from the map, last number found on top.
        if (cache_top >= CACHE_DEPTH) begin
          pos   = scan_from;
          found = 0;
          slot  = CACHE_DEPTH;
          while (pos < NUM_INODES && found < CACHE_DEPTH) begin
            if (!used_bits[pos]) begin
              slot--;
              free_cache[slot] = NUM_W'(pos);
              found++;
              scan_from = pos + 1;
            end
            pos++;
          end
          if (found != 0) cache_top = slot;
        end
        // A refill that found nothing leaves the cache empty: report none free.
        if (cache_top < CACHE_DEPTH) begin
          r.inode = free_cache[cache_top];
          cache_top++;
          used_bits[r.inode] = 1'b1;
          free_count--;
          r.status = STAT_ALLOCATED;
        end
      end
    end else if (int'(num) >= NUM_INODES) begin
      r.inode  = num;
      r.status = STAT_REJECTED;
    end else begin
      // Double free leaves everything as it was.
      if (used_bits[num]) begin
        used_bits[num] = 1'b0;
        free_count++;
        if (cache_top != 0) begin
          if (cache_top > CACHE_DEPTH) cache_top = CACHE_DEPTH;
          cache_top--;
          free_cache[cache_top] = num;
        end else if (int'(num) < scan_from) begin
          // Cache full: pull the scan start back so a later refill finds it.
          scan_from = int'(num);
        end
      end
      r.inode  = num;
      r.status = STAT_FREED;
    end
    expected_results.push_back(r);
  endtask

  // Draw an idle count; now and then flip into or out of a no-idle stretch.
  function automatic int draw_idle(inout bit fast_mode);
    if ($urandom_range(0, 31) == 0) fast_mode = !fast_mode;
    return fast_mode ? 0 : int'($urandom_range(0, 7));
  endfunction

  // Pick an inode the predictor holds as used, or -1 if none is.
  function automatic int pick_used();
    int start;
    int idx;
    start = $urandom_range(0, NUM_INODES - 1);
    for (int i = 0; i < NUM_INODES; i++) begin
      idx = (start + i) % NUM_INODES;
      if (used_bits[idx]) return idx;
    end
    return -1;
  endfunction

  // Hold the request queue short so picks track the predictor closely.
  task automatic queue_word(input logic op, input int num);
    request_t w;
    while (pending_requests.size() >= 4) @(posedge clk);
    w.op  = op;
    w.num = num[NUM_W-1:0];
    pending_requests.push_back(w);
    words_queued++;
  endtask

  task automatic queue_free_of_used();
    int n;
    n = pick_used();
    if (n < 0) n = $urandom_range(0, NUM_INODES - 1);
    queue_word(OP_FREE, n);
  endtask

  // Sample at the falling edge, after the driver's updates have settled.
  task automatic wait_all_done();
    while (pending_requests.size() != 0 || push || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Driver: offer the next request word, hold it until taken, then idle.
  always @(posedge clk) begin
    request_t nxt;
    if (!rst_n) begin
      push      <= 1'b0;
      send_wait = 0;
    end else begin
      if (push && !full) predict_allocator(in_operation, in_inode_number);
      if (!push || !full) begin
        if (send_wait > 0) begin
          send_wait--;
          push <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          nxt = pending_requests.pop_front();
          in_operation    <= nxt.op;
          in_inode_number <= nxt.num;
          push            <= 1'b1;
          send_wait = draw_idle(send_fast);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: take result words with random stalls and check against the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      pop       <= 1'b0;
      recv_wait = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $error("result word with nothing expected: inode %0d status %0d",
                 out_result_inode, out_status);
        end else begin
          want = expected_results.pop_front();
          if (out_result_inode !== want.inode) begin
            error_count++;
            $error("result_inode: expected %0d, actual %0d", want.inode, out_result_inode);
          end
          if (out_status !== want.status) begin
            error_count++;
            $error("status: expected %0d, actual %0d", want.status, out_status);
          end
        end
        recv_wait = draw_idle(recv_fast);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int sel;
    int guard;
    for (int i = 0; i < NUM_INODES; i++) used_bits[i] = 1'b0;
    for (int i = 0; i < CACHE_DEPTH; i++) free_cache[i] = '0;
    cache_top  = CACHE_DEPTH;
    free_count = NUM_INODES;
    scan_from  = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: first refill, pops, a free back onto the cache, double frees,
    // field extremes and alternating bit patterns of the inode number.
    queue_word(OP_ALLOC, 0);
    queue_word(OP_ALLOC, 9'h1FF);
    queue_word(OP_ALLOC, 0);
    queue_word(OP_FREE, 9'h1FF);
    queue_word(OP_FREE, CACHE_DEPTH - 1);
    queue_word(OP_FREE, CACHE_DEPTH - 1);
    queue_word(OP_FREE, 0);
    queue_word(OP_FREE, 9'h155);
    queue_word(OP_FREE, 9'h0AA);
    queue_word(OP_ALLOC, 9'h155);
    queue_word(OP_FREE, CACHE_DEPTH - 2);
    queue_word(OP_FREE, CACHE_DEPTH - 3);
    queue_word(OP_ALLOC, 0);
    queue_word(OP_ALLOC, 0);
    queue_word(OP_ALLOC, 0);
    queue_word(OP_FREE, CACHE_DEPTH - 2);

    // Mostly allocations, so the cache empties and refills repeat.
    for (int i = 0; i < 280; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) queue_word(OP_ALLOC, $urandom_range(0, NUM_INODES - 1));
      else if (sel < 9) queue_free_of_used();
      else queue_word(OP_FREE, $urandom_range(0, NUM_INODES - 1));
    end

    // Hold the sender until every result is back.
    wait_all_done();

    // Exhaust the map, then ask for a few more with nothing free.
    guard = 0;
    while (free_count != 0 && guard < 700) begin
      queue_word(OP_ALLOC, $urandom_range(0, NUM_INODES - 1));
      guard++;
    end
    repeat (4) queue_word(OP_ALLOC, $urandom_range(0, NUM_INODES - 1));

    // Free-heavy: fill the cache, then lower the scan start past a full cache.
    while (words_queued < RANDOM_WORDS + 16) begin
      sel = $urandom_range(0, 19);
      if (sel < 12) queue_free_of_used();
      else if (sel < 17) queue_word(OP_ALLOC, $urandom_range(0, NUM_INODES - 1));
      else queue_word(OP_FREE, $urandom_range(0, NUM_INODES - 1));
    end

    wait_all_done();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ifca_pkg.sv
sv/ifca_fifo.sv
sv/ifca_front.sv
sv/ifca_back.sv
sv/inode_free_cache_allocator_unit.sv
tb/tb_inode_free_cache_allocator_unit.sv
